/* rtl/vcs_pkg.sv */
// Package for the two-wire voice command sender: sizes, codes, phase encoding
// and the packed word, state and register types shared by all RTL files.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vcs_pkg;

  localparam int WORD_BITS  = 16;
  localparam int COUNT_BITS = 13;
  localparam int BITS_W     = $clog2(WORD_BITS + 1);
  localparam int IDX_W      = $clog2(WORD_BITS);
  localparam int CFG_BITS   = 13;
  localparam int SHORT_BITS = 8;
  localparam int REG_IDX_W  = 3;
  localparam int IN_WORD_W  = 16;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_SEND      = 2'd1,
    CMD_SEND_IDLE = 2'd2,
    CMD_RESET     = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    PHASE_IDLE   = 4'd0,
    PHASE_WAIT   = 4'd1,
    PHASE_START  = 4'd2,
    PHASE_LOW    = 4'd3,
    PHASE_HOLD   = 4'd4,
    PHASE_HIGH   = 4'd5,
    PHASE_GAP    = 4'd6,
    PHASE_FINISH = 4'd7,
    PHASE_RLOW   = 4'd8,
    PHASE_RWAIT  = 4'd9
  } phase_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_START      = 3'd0,
    REG_CLOCK_LOW  = 3'd1,
    REG_DATA_HOLD  = 3'd2,
    REG_CLOCK_HIGH = 3'd3,
    REG_GAP        = 3'd4,
    REG_FINISH     = 3'd5,
    REG_RESET_LOW  = 3'd6,
    REG_RESET_WAIT = 3'd7
  } reg_idx_t;

  typedef struct packed {
    cmd_t                 command;
    logic [IN_WORD_W-1:0] word;
    logic                 busy_pin;
  } vcs_req_t;

  typedef struct packed {
    logic clock_pin;
    logic data_pin;
    logic reset_pin;
    logic ready_res;
    logic accepted;
    logic playing;
  } vcs_rsp_t;

  typedef struct packed {
    phase_t                phase;
    logic [COUNT_BITS-1:0] tick_count;
    logic [WORD_BITS-1:0]  shift_word;
    logic [BITS_W-1:0]     bits_left;
    logic                  clock_level;
    logic                  data_level;
    logic                  reset_level;
  } vcs_state_t;

  typedef struct packed {
    logic [CFG_BITS-1:0]   start_ticks;
    logic [SHORT_BITS-1:0] clock_low_ticks;
    logic [SHORT_BITS-1:0] data_hold_ticks;
    logic [SHORT_BITS-1:0] clock_high_ticks;
    logic [CFG_BITS-1:0]   gap_ticks;
    logic [CFG_BITS-1:0]   finish_ticks;
    logic [CFG_BITS-1:0]   reset_low_ticks;
    logic [CFG_BITS-1:0]   reset_wait_ticks;
  } vcs_cfg_t;

  localparam vcs_cfg_t CFG_RESET = '{
    start_ticks:      13'd40,
    clock_low_ticks:  8'd1,
    data_hold_ticks:  8'd1,
    clock_high_ticks: 8'd2,
    gap_ticks:        13'd40,
    finish_ticks:     13'd400,
    reset_low_ticks:  13'd100,
    reset_wait_ticks: 13'd6000
  };

  localparam vcs_state_t STATE_RESET = '{
    phase:       PHASE_IDLE,
    tick_count:  '0,
    shift_word:  '0,
    bits_left:   '0,
    clock_level: 1'b1,
    data_level:  1'b0,
    reset_level: 1'b1
  };

endpackage

`default_nettype wire

/* rtl/vcs_next.sv */
// Next-state and result logic of the voice command sender for one word.
// Depends on vcs_pkg; purely combinational, used by the top level.
`timescale 1ns / 1ps
`default_nettype none

module vcs_next import vcs_pkg::*; (
  input  vcs_state_t state,
  input  vcs_cfg_t   cfg,
  input  vcs_req_t   item,
  output vcs_state_t state_next,
  output vcs_rsp_t   result
);

  localparam int DUR_W     = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
  localparam int COUNT_MAX = (1 << COUNT_BITS) - 1;

  function automatic logic [COUNT_BITS-1:0] duration(input vcs_cfg_t c, input phase_t p);
    logic [CFG_BITS-1:0] raw;
    logic [DUR_W-1:0]    wide;
    begin
      case (p)
        PHASE_START:  raw = c.start_ticks;
        PHASE_LOW:    raw = CFG_BITS'(c.clock_low_ticks);
        PHASE_HOLD:   raw = CFG_BITS'(c.data_hold_ticks);
        PHASE_HIGH:   raw = CFG_BITS'(c.clock_high_ticks);
        PHASE_GAP:    raw = c.gap_ticks;
        PHASE_FINISH: raw = c.finish_ticks;
        PHASE_RLOW:   raw = c.reset_low_ticks;
        PHASE_RWAIT:  raw = c.reset_wait_ticks;
        default:      raw = '0;
      endcase
      wide = DUR_W'(raw);
      if (wide > DUR_W'(COUNT_MAX)) begin
        duration = COUNT_BITS'(COUNT_MAX);
      end else begin
        duration = wide[COUNT_BITS-1:0];
      end
    end
  endfunction

  function automatic logic timed(input phase_t p);
    timed = (p != PHASE_IDLE) && (p != PHASE_WAIT);
  endfunction

  function automatic vcs_state_t enter(input vcs_state_t s, input phase_t p);
    vcs_state_t r;
    begin
      r = s;
      r.phase = p;
      r.tick_count = '0;
      case (p)
        PHASE_START, PHASE_LOW: begin
          r.clock_level = 1'b0;
        end
        PHASE_HOLD: begin
          r.clock_level = 1'b0;
          r.data_level = s.shift_word[WORD_BITS-1];
        end
        PHASE_HIGH, PHASE_GAP, PHASE_FINISH: begin
          r.clock_level = 1'b1;
        end
        PHASE_RLOW: begin
          r.clock_level = 1'b0;
          r.reset_level = 1'b0;
        end
        PHASE_RWAIT: begin
          r.clock_level = 1'b1;
          r.reset_level = 1'b1;
        end
        default: begin
        end
      endcase
      enter = r;
    end
  endfunction

  function automatic vcs_state_t advance(input vcs_state_t s);
    vcs_state_t r;
    begin
      r = s;
      case (s.phase)
        PHASE_START:  r = enter(s, PHASE_LOW);
        PHASE_LOW:    r = enter(s, PHASE_HOLD);
        PHASE_HOLD:   r = enter(s, PHASE_HIGH);
        PHASE_HIGH: begin
          r.shift_word = s.shift_word << 1;
          if (s.bits_left != '0) begin
            r.bits_left = s.bits_left - BITS_W'(1);
          end
          r = enter(r, (r.bits_left != '0) ? PHASE_GAP : PHASE_FINISH);
        end
        PHASE_GAP:    r = enter(s, PHASE_LOW);
        PHASE_RLOW:   r = enter(s, PHASE_RWAIT);
        default:      r = enter(s, PHASE_IDLE);
      endcase
      advance = r;
    end
  endfunction

  function automatic vcs_state_t skip(input vcs_state_t s, input vcs_cfg_t c);
    if (timed(s.phase) && (duration(c, s.phase) == '0)) begin
      skip = advance(s);
    end else begin
      skip = s;
    end
  endfunction

  // When all four per-bit phases are zero, the remaining bits go out at once.
  function automatic logic runs_out(input vcs_state_t s, input vcs_cfg_t c);
    logic in_loop;
    logic all_zero;
    begin
      in_loop = (s.phase == PHASE_LOW) || (s.phase == PHASE_HOLD) ||
                (s.phase == PHASE_HIGH) || (s.phase == PHASE_GAP);
      all_zero = (duration(c, PHASE_LOW) == '0) && (duration(c, PHASE_HOLD) == '0) &&
                 (duration(c, PHASE_HIGH) == '0) && (duration(c, PHASE_GAP) == '0);
      runs_out = in_loop && all_zero && (s.bits_left != '0);
    end
  endfunction

  function automatic vcs_state_t run_out(input vcs_state_t s);
    vcs_state_t       r;
    logic [IDX_W-1:0] idx;
    begin
      r = s;
      idx = IDX_W'(WORD_BITS - int'(s.bits_left));
      if (!((s.phase == PHASE_HIGH) && (s.bits_left == BITS_W'(1)))) begin
        r.data_level = s.shift_word[idx];
      end
      r.shift_word = s.shift_word << s.bits_left;
      r.bits_left = '0;
      run_out = enter(r, PHASE_FINISH);
    end
  endfunction

  function automatic vcs_state_t start_frame(input vcs_state_t s);
    vcs_state_t r;
    begin
      r = s;
      r.bits_left = BITS_W'(WORD_BITS);
      start_frame = enter(r, PHASE_START);
    end
  endfunction

  vcs_state_t landing;
  vcs_state_t chain [0:6];
  logic       settle_en;
  logic       taken;
  logic [COUNT_BITS-1:0] count_inc;

  assign count_inc = state.tick_count + COUNT_BITS'(1);

  always_comb begin
    landing = state;
    settle_en = 1'b0;
    taken = 1'b0;
    case (item.command)
      CMD_TICK: begin
        if (state.phase == PHASE_WAIT) begin
          if (item.busy_pin) begin
            landing = start_frame(state);
            settle_en = 1'b1;
          end
        end else if (timed(state.phase)) begin
          landing.tick_count = count_inc;
          if (count_inc >= duration(cfg, state.phase)) begin
            landing = advance(landing);
            settle_en = 1'b1;
          end
        end
      end
      default: begin
        if (state.phase == PHASE_IDLE) begin
          taken = 1'b1;
          settle_en = 1'b1;
          if (item.command == CMD_RESET) begin
            landing = enter(state, PHASE_RLOW);
          end else begin
            landing.shift_word = WORD_BITS'(item.word);
            if ((item.command == CMD_SEND) || item.busy_pin) begin
              landing = start_frame(landing);
            end else begin
              landing = enter(landing, PHASE_WAIT);
            end
          end
        end
      end
    endcase
  end

  always_comb begin
    chain[0] = skip(landing, cfg);
    chain[1] = runs_out(chain[0], cfg) ? run_out(chain[0]) : chain[0];
    for (int i = 2; i < 7; i++) begin
      chain[i] = skip(chain[i-1], cfg);
    end
  end

  assign state_next = settle_en ? chain[6] : landing;

  assign result = '{
    clock_pin: state_next.clock_level,
    data_pin:  state_next.data_level,
    reset_pin: state_next.reset_level,
    ready_res: (state_next.phase == PHASE_IDLE),
    accepted:  taken,
    playing:   !item.busy_pin
  };

endmodule

`default_nettype wire

/* rtl/two_wire_voice_command_sender.sv */
// Top level of the two-wire voice command sender: handshakes, registers,
// input and result stages. Depends on vcs_pkg and vcs_next.
//
//   Channel   Direction  Handshake            Payload
//   req       in         req_valid/req_stall  vcs_req_t  (command, word, busy_pin)
//   rsp       out        rsp_valid/rsp_stall  vcs_rsp_t  (pin levels, ready, accepted)
//   cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each word passes through the input register, then through the next-state
// logic into the result register. One word is accepted per cycle while the
// result is not stalled; the sender state updates with the result register.
// Reset is synchronous and restores the register defaults and the idle state.
// A stalled result holds the result register, and the input register behind it.
`timescale 1ns / 1ps
`default_nettype none

module two_wire_voice_command_sender import vcs_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output logic                       req_stall,
  input  wire vcs_req_t              req_word,
  output logic                       rsp_valid,
  input  wire logic                  rsp_stall,
  output vcs_rsp_t                   rsp_word,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [REG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_BITS-1:0]   cfg_data
);

  vcs_cfg_t   cfg;
  vcs_state_t state;
  vcs_state_t state_next;
  vcs_rsp_t   result;
  vcs_req_t   item;
  logic       item_valid;
  logic       adv;

  assign cfg_ready = 1'b1;
  assign adv = item_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = item_valid && !adv;

  vcs_next u_next (
    .state      (state),
    .cfg        (cfg),
    .item       (item),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_START:      cfg.start_ticks <= cfg_data;
        REG_CLOCK_LOW:  cfg.clock_low_ticks <= cfg_data[SHORT_BITS-1:0];
        REG_DATA_HOLD:  cfg.data_hold_ticks <= cfg_data[SHORT_BITS-1:0];
        REG_CLOCK_HIGH: cfg.clock_high_ticks <= cfg_data[SHORT_BITS-1:0];
        REG_GAP:        cfg.gap_ticks <= cfg_data;
        REG_FINISH:     cfg.finish_ticks <= cfg_data;
        REG_RESET_LOW:  cfg.reset_low_ticks <= cfg_data;
        REG_RESET_WAIT: cfg.reset_wait_ticks <= cfg_data;
        default:        cfg <= cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      rsp_valid <= 1'b0;
      state <= STATE_RESET;
    end else begin
      if (!req_stall) begin
        item_valid <= req_valid;
      end
      if (adv) begin
        state <= state_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      item <= req_word;
    end
    if (adv) begin
      rsp_word <= result;
    end
  end

  a_refused_when_busy: assert property (@(posedge clk) disable iff (rst)
    adv && (state.phase != PHASE_IDLE) && (item.command != CMD_TICK) |=> !rsp_word.accepted)
    else $error("command taken while a frame or reset was in progress");

  a_reset_pin_phase: assert property (@(posedge clk) disable iff (rst)
    !state.reset_level |-> (state.phase == PHASE_RLOW))
    else $error("reset line low outside the reset pulse");

  a_bits_in_range: assert property (@(posedge clk) disable iff (rst)
    state.bits_left <= BITS_W'(WORD_BITS))
    else $error("bit counter beyond word length");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> item_valid && rsp_valid && rsp_stall)
    else $error("input stalled without a stalled result");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(state))
    else $error("sender state changed without a word");

endmodule

`default_nettype wire
